// ----- sv/psc_pkg.sv -----
// Shared types, constants and command/status structs for the pulse shape charge ratio block.
`default_nettype none

package psc_pkg;

  // Data widths and record limits
  localparam int SAMPLE_BITS   = 14;
  localparam int MAX_SAMPLES   = 2048;
  localparam int CNT_BITS      = $clog2(MAX_SAMPLES + 1);
  localparam int BIN_VAL_BITS  = SAMPLE_BITS + 2;
  localparam int ACC_BITS      = 28;
  localparam int WIN_BITS      = 13;
  localparam int THR_BITS      = 14;
  localparam int RATIO_BITS    = 16;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 14;
  localparam int DIV_STEPS     = RATIO_BITS;
  localparam int DIV_CNT_BITS  = $clog2(DIV_STEPS);

  localparam logic [ACC_BITS-1:0]   ACC_MAX   = {ACC_BITS{1'b1}};
  localparam logic [RATIO_BITS-1:0] RATIO_MAX = {RATIO_BITS{1'b1}};

  // Register reset values
  localparam logic [WIN_BITS-1:0] TOTAL_START_RST = WIN_BITS'(600);
  localparam logic [WIN_BITS-1:0] TOTAL_END_RST   = WIN_BITS'(2000);
  localparam logic [WIN_BITS-1:0] TAIL_START_RST  = WIN_BITS'(1010);
  localparam logic [THR_BITS-1:0] PEAK_LIMIT_RST  = THR_BITS'(10);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_TOTAL_START = 2'd0,
    CFG_TOTAL_END   = 2'd1,
    CFG_TAIL_START  = 2'd2,
    CFG_PEAK_LIMIT  = 2'd3
  } cfg_idx_t;

  // Input request payload
  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample;
    logic                   last;
  } wave_t;

  // Result request payload
  typedef struct packed {
    logic [SAMPLE_BITS-1:0] peak_height;
    logic [ACC_BITS-1:0]    total_charge_quarters;
    logic [ACC_BITS-1:0]    tail_charge_quarters;
    logic [RATIO_BITS-1:0]  tail_ratio;
    logic                   accepted;
    logic                   zero_total;
  } result_t;

  // End-of-record bin selection
  typedef enum logic [1:0] {
    FLUSH_NONE  = 2'd0,
    FLUSH_THREE = 2'd1,
    FLUSH_TWO   = 2'd2
  } flush_t;

  // Controller to datapath
  typedef struct packed {
    logic   take_sample;
    flush_t flush;
    logic   div_init;
    logic   div_step;
    logic   load_result;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic result_full;
  } dp_status_t;

endpackage

`default_nettype wire

// ----- sv/psc_ctrl.sv -----
// Controller state machine: sample intake, end-of-record flush, divide and result load.
`default_nettype none

module psc_ctrl
  import psc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       wave_valid,
  input  wire logic       wave_last,
  output logic            wave_stall,
  input  wire dp_status_t status,
  output ctrl_cmd_t       cmd
);

  typedef enum logic [5:0] {
    ST_RUN      = 6'b000001,
    ST_FLUSH3   = 6'b000010,
    ST_FLUSH2   = 6'b000100,
    ST_DIV_INIT = 6'b001000,
    ST_DIV      = 6'b010000,
    ST_DONE     = 6'b100000
  } state_t;

  state_t                  state, state_next;
  logic [DIV_CNT_BITS-1:0] div_cnt, div_cnt_next;
  logic                    take;

  assign wave_stall = (state != ST_RUN);
  assign take       = wave_valid && !wave_stall;

  // Next state and commands
  always_comb begin
    state_next      = state;
    div_cnt_next    = div_cnt;
    cmd.take_sample = 1'b0;
    cmd.flush       = FLUSH_NONE;
    cmd.div_init    = 1'b0;
    cmd.div_step    = 1'b0;
    cmd.load_result = 1'b0;
    unique case (state)
      ST_RUN: begin
        cmd.take_sample = take;
        if (take && wave_last) state_next = ST_FLUSH3;
      end
      ST_FLUSH3: begin
        cmd.flush  = FLUSH_THREE;
        state_next = ST_FLUSH2;
      end
      ST_FLUSH2: begin
        cmd.flush  = FLUSH_TWO;
        state_next = ST_DIV_INIT;
      end
      ST_DIV_INIT: begin
        cmd.div_init = 1'b1;
        div_cnt_next = '0;
        state_next   = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        div_cnt_next = div_cnt + DIV_CNT_BITS'(1);
        if (div_cnt == DIV_CNT_BITS'(DIV_STEPS - 1)) state_next = ST_DONE;
      end
      ST_DONE: begin
        // wait for the output register to free up
        if (!status.result_full) begin
          cmd.load_result = 1'b1;
          state_next      = ST_RUN;
        end
      end
      default: state_next = ST_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_RUN;
      div_cnt <= '0;
    end else begin
      state   <= state_next;
      div_cnt <= div_cnt_next;
    end
  end

endmodule

`default_nettype wire

// ----- sv/psc_dp.sv -----
// Datapath: config registers, boxcar window sums, peak, ratio divider and output register.
`default_nettype none

module psc_dp
  import psc_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire ctrl_cmd_t                cmd,
  input  wire wave_t                    wave_data,
  input  wire logic                     cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_wdata,
  input  wire logic                     result_stall,
  output dp_status_t                    status,
  output logic                          result_valid,
  output result_t                       result_data
);

  logic [WIN_BITS-1:0]    total_start, total_end, tail_start;
  logic [THR_BITS-1:0]    peak_limit;

  logic [SAMPLE_BITS-1:0] sample_delay [3];
  logic [CNT_BITS-1:0]    bin_position;
  logic [ACC_BITS-1:0]    total_acc, tail_acc;
  logic [SAMPLE_BITS-1:0] running_peak;

  logic [ACC_BITS-1:0]    div_rem;
  logic [RATIO_BITS-1:0]  div_quo;

  logic                    add_en;
  logic [CNT_BITS-1:0]     add_bin;
  logic [BIN_VAL_BITS-1:0] add_val;
  logic                    in_total, in_tail;
  logic [ACC_BITS:0]       total_sum, tail_sum;
  logic [ACC_BITS-1:0]     total_acc_next, tail_acc_next;
  logic                    sample_ok;
  logic [BIN_VAL_BITS-1:0] d0, d1, d2, s_ext;
  logic [ACC_BITS:0]       rem_sh;
  logic                    rem_ge;
  logic                    zero_total;
  logic [RATIO_BITS-1:0]   ratio;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      total_start <= TOTAL_START_RST;
      total_end   <= TOTAL_END_RST;
      tail_start  <= TAIL_START_RST;
      peak_limit  <= PEAK_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_TOTAL_START: total_start <= cfg_wdata[WIN_BITS-1:0];
        CFG_TOTAL_END:   total_end   <= cfg_wdata[WIN_BITS-1:0];
        CFG_TAIL_START:  tail_start  <= cfg_wdata[WIN_BITS-1:0];
        CFG_PEAK_LIMIT:  peak_limit  <= cfg_wdata[THR_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign d0        = BIN_VAL_BITS'(sample_delay[0]);
  assign d1        = BIN_VAL_BITS'(sample_delay[1]);
  assign d2        = BIN_VAL_BITS'(sample_delay[2]);
  assign s_ext     = BIN_VAL_BITS'(wave_data.sample);
  assign sample_ok = cmd.take_sample && (bin_position < CNT_BITS'(MAX_SAMPLES));

  // Pick the bin being closed this cycle
  always_comb begin
    add_en  = 1'b0;
    add_bin = bin_position - CNT_BITS'(2);
    add_val = d0 + d1 + d2 + s_ext;
    unique case (cmd.flush)
      FLUSH_NONE: begin
        add_en = sample_ok && (bin_position >= CNT_BITS'(3));
      end
      FLUSH_THREE: begin
        add_en  = bin_position >= CNT_BITS'(3);
        add_val = d0 + d1 + d2;
      end
      FLUSH_TWO: begin
        add_en  = bin_position >= CNT_BITS'(2);
        add_bin = bin_position - CNT_BITS'(1);
        add_val = d0 + d1;
      end
      default: add_en = 1'b0;
    endcase
  end

  // Window tests and saturating accumulation
  assign in_total = ((WIN_BITS + 1)'(add_bin) > (WIN_BITS + 1)'(total_start))
                 && ((WIN_BITS + 1)'(add_bin) <= (WIN_BITS + 1)'(total_end));
  assign in_tail  = (WIN_BITS + 1)'(add_bin)
                 >= ((WIN_BITS + 1)'(tail_start) + (WIN_BITS + 1)'(2));
  assign total_sum = (ACC_BITS + 1)'(total_acc) + (ACC_BITS + 1)'(add_val);
  assign tail_sum  = (ACC_BITS + 1)'(tail_acc) + (ACC_BITS + 1)'(add_val);

  always_comb begin
    total_acc_next = total_acc;
    tail_acc_next  = tail_acc;
    if (add_en && in_total) begin
      total_acc_next = total_sum[ACC_BITS] ? ACC_MAX : total_sum[ACC_BITS-1:0];
      if (in_tail) tail_acc_next = tail_sum[ACC_BITS] ? ACC_MAX : tail_sum[ACC_BITS-1:0];
    end
  end

  // Record state: delay line, bin count, peak, sums
  always_ff @(posedge clk) begin
    if (rst || cmd.load_result) begin
      sample_delay[0] <= '0;
      sample_delay[1] <= '0;
      sample_delay[2] <= '0;
      bin_position    <= '0;
      total_acc       <= '0;
      tail_acc        <= '0;
      running_peak    <= '0;
    end else begin
      total_acc <= total_acc_next;
      tail_acc  <= tail_acc_next;
      if (sample_ok) begin
        if (wave_data.sample > running_peak) running_peak <= wave_data.sample;
        sample_delay[2] <= sample_delay[1];
        sample_delay[1] <= sample_delay[0];
        sample_delay[0] <= wave_data.sample;
        bin_position    <= bin_position + CNT_BITS'(1);
      end
    end
  end

  // Restoring divider, one quotient bit per cycle; only used when tail < total
  assign rem_sh = {div_rem, 1'b0};
  assign rem_ge = rem_sh >= (ACC_BITS + 1)'(total_acc);

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      div_rem <= tail_acc;
      div_quo <= '0;
    end else if (cmd.div_step) begin
      div_rem <= rem_ge ? ACC_BITS'(rem_sh - (ACC_BITS + 1)'(total_acc))
                        : rem_sh[ACC_BITS-1:0];
      div_quo <= {div_quo[RATIO_BITS-2:0], rem_ge};
    end
  end

  assign zero_total = (total_acc == '0);

  // tail at or above total saturates the Q0.16 ratio; a zero total gives a zero ratio
  always_comb begin
    priority if (zero_total) ratio = '0;
    else if (tail_acc >= total_acc) ratio = RATIO_MAX;
    else ratio = div_quo;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.load_result) begin
      result_valid <= 1'b1;
    end else if (result_valid && !result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      result_data.peak_height           <= running_peak;
      result_data.total_charge_quarters <= total_acc;
      result_data.tail_charge_quarters  <= tail_acc;
      result_data.tail_ratio            <= ratio;
      result_data.accepted              <= (THR_BITS'(running_peak) > peak_limit);
      result_data.zero_total            <= zero_total;
    end
  end

  assign status.result_full = result_valid && result_stall;

endmodule

`default_nettype wire

// ----- sv/pulse_shape_charge_ratio.sv -----
// Top level of the charge-comparison pulse shape discrimination block.
//
// Usage:
//   wave channel (wave_valid/wave_stall/wave_data) carries one raw ADC sample
//   per request, with the last flag set on the final sample of a record.
//   result channel (result_valid/result_stall/result_data) carries one result
//   per record: peak, total and tail charge in quarter units, tail/total as
//   Q0.16, the threshold decision and a zero-total flag.
//   cfg_we/cfg_index/cfg_wdata write the window and threshold registers;
//   write them only while no record is in progress.
// Throughput: one sample per cycle inside a record. After the last sample the
//   wave channel stalls while the controller closes the final bins (ST_FLUSH3,
//   ST_FLUSH2), loads the divider (ST_DIV_INIT), runs the bit-serial restoring
//   divide (ST_DIV) and loads the output register (ST_DONE).
// The output register lets the next record stream in while a result waits;
//   if that record also ends before the result is taken, the wave channel
//   stays stalled until result_stall drops.
// Reset (rst, synchronous) restores the register defaults, empties the
//   record and drops result_valid.
`default_nettype none

module pulse_shape_charge_ratio
  import psc_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     wave_valid,
  output logic                          wave_stall,
  input  wire wave_t                    wave_data,
  output logic                          result_valid,
  input  wire logic                     result_stall,
  output result_t                       result_data,
  input  wire logic                     cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_wdata
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  psc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .wave_valid (wave_valid),
    .wave_last  (wave_data.last),
    .wave_stall (wave_stall),
    .status     (status),
    .cmd        (cmd)
  );

  psc_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .wave_data    (wave_data),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .result_stall (result_stall),
    .status       (status),
    .result_valid (result_valid),
    .result_data  (result_data)
  );

endmodule

`default_nettype wire
